// ===== src/stfsm_pkg.sv =====
// Shared widths, defaults and codes for the span to file segment mapper.
`default_nettype none
package stfsm_pkg;
   localparam int MAX_FILES_DEF   = 64;
   localparam int LENGTH_BITS_DEF = 44;

   localparam int IDX_W    = 6;   // load_index, segment_file
   localparam int LLEN_W   = 44;  // load_length, segment_offset
   localparam int PIDX_W   = 20;
   localparam int POFS_W   = 24;
   localparam int SPAN_W   = 25;  // span_length, segment_bytes
   localparam int PSIZE_W  = 25;
   localparam int FCNT_W   = 7;
   localparam int CSR_W    = 25;
   localparam int CSR_IDX_W = 1;
   localparam int PROD_W   = PIDX_W + PSIZE_W;

   localparam logic [PSIZE_W-1:0] PIECE_SIZE_RST = PSIZE_W'(16384);
   localparam logic [FCNT_W-1:0]  FILE_COUNT_RST = FCNT_W'(1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PIECE_SIZE = 1'b0,
      CSR_FILE_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_MAP  = 1'b1
   } command_type;

   typedef enum logic {
      STATUS_OK    = 1'b0,
      STATUS_RANGE = 1'b1
   } status_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_MUL    = 6'b000010,
      ST_PRIME1 = 6'b000100,
      ST_FIND   = 6'b001000,
      ST_PRIME2 = 6'b010000,
      ST_EMIT   = 6'b100000
   } state_type;
endpackage
`default_nettype wire

// ===== src/span_to_file_segment_mapper_unit.sv =====
// Top level: maps a piece span onto segments of a file length table.
`default_nettype none
// A load transaction (req_command = 0) writes one file length and gives no result.
// A map transaction, once accepted, first multiplies piece_index by piece_size, then
// does the position add, then reads the table one entry at a time from file 0 up to the
// file holding the span end, then restarts the table read, then walks from the start
// file to the end file, each file of nonzero length giving one result. An error or an
// empty span ends right after the first walk, and a file_count of zero ends the map right
// after the position add. The length table sits in a synchronous memory with one read
// port, read one entry per cycle, and both walks are bound by that port. busy falls
// in the cycle in which the final result stands on the rsp_ ports. The receiver cannot
// stall, so each result stands on the rsp_ ports for one cycle with rsp_valid high, and
// the last one carries rsp_last_segment.
module span_to_file_segment_mapper_unit #(
   parameter int MAX_FILES   = stfsm_pkg::MAX_FILES_DEF,
   parameter int LENGTH_BITS = stfsm_pkg::LENGTH_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic                            req_command,
   input  wire logic [stfsm_pkg::IDX_W-1:0]     req_load_index,
   input  wire logic [stfsm_pkg::LLEN_W-1:0]    req_load_length,
   input  wire logic [stfsm_pkg::PIDX_W-1:0]    req_piece_index,
   input  wire logic [stfsm_pkg::POFS_W-1:0]    req_piece_offset,
   input  wire logic [stfsm_pkg::SPAN_W-1:0]    req_span_length,
   output logic                                 rsp_valid,
   output logic [stfsm_pkg::IDX_W-1:0]          rsp_segment_file,
   output logic [stfsm_pkg::LLEN_W-1:0]         rsp_segment_offset,
   output logic [stfsm_pkg::SPAN_W-1:0]         rsp_segment_bytes,
   output logic                                 rsp_status,
   output logic                                 rsp_last_segment,
   input  wire logic                            csr_we,
   input  wire logic [stfsm_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [stfsm_pkg::CSR_W-1:0]     csr_wdata
);
   import stfsm_pkg::*;

   localparam int LB  = LENGTH_BITS;
   localparam int AW  = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
   localparam int CW  = $clog2(MAX_FILES + 1);
   localparam int FW  = (CW > FCNT_W) ? CW : FCNT_W;
   localparam int POS_W = ((PROD_W + 2) > LB) ? (PROD_W + 2) : LB;
   localparam int WW  = POS_W + 1;
   localparam int DW  = ((LB > SPAN_W) ? LB : SPAN_W) + 1;

   // configuration
   logic [PSIZE_W-1:0] piece_size_ff;
   logic [FCNT_W-1:0]  file_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         piece_size_ff <= PIECE_SIZE_RST;
         file_count_ff <= FILE_COUNT_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_PIECE_SIZE: piece_size_ff <= csr_wdata[PSIZE_W-1:0];
            CSR_FILE_COUNT: file_count_ff <= csr_wdata[FCNT_W-1:0];
            default: ;
         endcase
      end
   end

   logic [FW-1:0] count_wide;
   logic [CW-1:0] count;
   assign count_wide = (FW'(file_count_ff) > FW'(MAX_FILES)) ? FW'(MAX_FILES)
                                                              : FW'(file_count_ff);
   assign count = count_wide[CW-1:0];

   // control and working registers
   state_type           state_ff, state_in;
   logic [PIDX_W-1:0]   pidx_ff, pidx_in;
   logic [POFS_W-1:0]   pofs_ff, pofs_in;
   logic [SPAN_W-1:0]   rem_ff, rem_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [WW-1:0]       pos_ff, pos_in;
   logic [WW-1:0]       end_ff, end_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       start_ff, start_in;
   logic [LB-1:0]       off_ff, off_in;
   logic [LB-1:0]       avail0_ff, avail0_in;
   logic                found_ff, found_in;
   logic                first_ff, first_in;

   logic                out_valid_ff, out_valid_in;
   logic [IDX_W-1:0]    out_file_ff, out_file_in;
   logic [LLEN_W-1:0]   out_ofs_ff, out_ofs_in;
   logic [SPAN_W-1:0]   out_bytes_ff, out_bytes_in;
   logic                out_status_ff, out_status_in;
   logic                out_last_ff, out_last_in;

   // length table
   logic [LB-1:0] length_mem [MAX_FILES];
   logic [LB-1:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic [CW-1:0] idx_next;
   logic [IDX_W+AW-1:0]  ld_idx_ext;
   logic [LLEN_W+LB-1:0] ld_len_ext;
   logic          ld_we;

   assign idx_next   = idx_ff + CW'(1);
   assign ld_idx_ext = {{AW{1'b0}}, req_load_index};
   assign ld_len_ext = {{LB{1'b0}}, req_load_length};
   assign ld_we = start && !busy && (req_command == CMD_LOAD)
                  && (ld_idx_ext < (IDX_W + AW)'(MAX_FILES));

   always_comb begin
      logic [CW+AW-1:0] a_ext;
      if (state_ff == ST_PRIME1 || state_ff == ST_PRIME2) a_ext = {{AW{1'b0}}, idx_ff};
      else                                                a_ext = {{AW{1'b0}}, idx_next};
      rd_addr = a_ext[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (ld_we) begin
         length_mem[ld_idx_ext[AW-1:0]] <= ld_len_ext[LB-1:0];
      end
      rd_data_ff <= length_mem[rd_addr];
   end

   // datapath
   logic [WW-1:0]  len_w, d_pos, d_end, avail0_w;
   logic           hit_start, fits, at_end;
   logic [LB-1:0]  avail;
   logic [DW-1:0]  diff;
   logic           emit_last;
   logic [CW+IDX_W-1:0] idx_o_ext;
   logic [LB+LLEN_W-1:0] off_o_ext;
   logic [LB+SPAN_W-1:0] avail_ext;

   assign len_w     = {{(WW-LB){1'b0}}, rd_data_ff};
   assign d_pos     = pos_ff - len_w;
   assign d_end     = end_ff - len_w;
   assign avail0_w  = len_w - pos_ff;
   assign hit_start = !found_ff && d_pos[WW-1];
   assign fits      = (found_ff || hit_start) && (d_end[WW-1] || (d_end == '0));
   assign at_end    = (idx_next == count);

   assign avail     = first_ff ? avail0_ff : rd_data_ff;
   assign diff      = DW'(rem_ff) - DW'(avail);
   assign emit_last = diff[DW-1] || (diff == '0);
   assign idx_o_ext = {{IDX_W{1'b0}}, idx_ff};
   assign off_o_ext = {{LLEN_W{1'b0}}, off_ff};
   assign avail_ext = {{SPAN_W{1'b0}}, avail};

   always_comb begin
      logic [LB+LLEN_W-1:0] pos_o_ext;
      state_in   = state_ff;
      pidx_in    = pidx_ff;
      pofs_in    = pofs_ff;
      rem_in     = rem_ff;
      prod_in    = prod_ff;
      pos_in     = pos_ff;
      end_in     = end_ff;
      idx_in     = idx_ff;
      start_in   = start_ff;
      off_in     = off_ff;
      avail0_in  = avail0_ff;
      found_in   = found_ff;
      first_in   = first_ff;
      out_valid_in  = 1'b0;
      out_file_in   = out_file_ff;
      out_ofs_in    = out_ofs_ff;
      out_bytes_in  = out_bytes_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;
      pos_o_ext     = {{LLEN_W{1'b0}}, pos_ff[LB-1:0]};

      case (state_ff)
         ST_IDLE: begin
            if (start && (req_command == CMD_MAP)) begin
               pidx_in  = req_piece_index;
               pofs_in  = req_piece_offset;
               rem_in   = req_span_length;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(pidx_ff) * PROD_W'(piece_size_ff);
            idx_in   = '0;
            found_in = 1'b0;
            state_in = ST_PRIME1;
         end
         ST_PRIME1: begin
            pos_in = WW'(prod_ff) + WW'(pofs_ff);
            end_in = WW'(prod_ff) + WW'(pofs_ff) + WW'(rem_ff);
            if (count == '0) begin
               out_valid_in  = 1'b1;
               out_file_in   = '0;
               out_ofs_in    = '0;
               out_bytes_in  = '0;
               out_status_in = STATUS_RANGE;
               out_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            // walk the table: locate the start file and the file holding the span end
            end_in = d_end;
            if (hit_start) begin
               found_in  = 1'b1;
               start_in  = idx_ff;
               off_in    = pos_ff[LB-1:0];
               avail0_in = avail0_w[LB-1:0];
            end else if (!found_ff) begin
               pos_in = d_pos;
            end
            if (fits) begin
               if (rem_ff == '0) begin
                  // empty span: start position only (end == start, so hit here)
                  out_valid_in  = 1'b1;
                  out_file_in   = idx_o_ext[IDX_W-1:0];
                  out_ofs_in    = pos_o_ext[LLEN_W-1:0];
                  out_bytes_in  = '0;
                  out_status_in = STATUS_OK;
                  out_last_in   = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  idx_in   = hit_start ? idx_ff : start_ff;
                  state_in = ST_PRIME2;
               end
            end else if (at_end) begin
               out_valid_in  = 1'b1;
               out_file_in   = '0;
               out_ofs_in    = '0;
               out_bytes_in  = '0;
               out_status_in = STATUS_RANGE;
               out_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               idx_in = idx_next;
            end
         end
         ST_PRIME2: begin
            first_in = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            idx_in   = idx_next;
            first_in = 1'b0;
            if (avail != '0) begin
               out_valid_in  = 1'b1;
               out_file_in   = idx_o_ext[IDX_W-1:0];
               out_ofs_in    = first_ff ? off_o_ext[LLEN_W-1:0] : '0;
               out_status_in = STATUS_OK;
               out_last_in   = emit_last;
               if (emit_last) begin
                  out_bytes_in = rem_ff;
                  rem_in       = '0;
                  state_in     = ST_IDLE;
               end else begin
                  out_bytes_in = avail_ext[SPAN_W-1:0];
                  rem_in       = diff[SPAN_W-1:0];
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff       <= pidx_in;
      pofs_ff       <= pofs_in;
      rem_ff        <= rem_in;
      prod_ff       <= prod_in;
      pos_ff        <= pos_in;
      end_ff        <= end_in;
      idx_ff        <= idx_in;
      start_ff      <= start_in;
      off_ff        <= off_in;
      avail0_ff     <= avail0_in;
      found_ff      <= found_in;
      first_ff      <= first_in;
      out_file_ff   <= out_file_in;
      out_ofs_ff    <= out_ofs_in;
      out_bytes_ff  <= out_bytes_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = out_valid_ff;
   assign rsp_segment_file   = out_file_ff;
   assign rsp_segment_offset = out_ofs_ff;
   assign rsp_segment_bytes  = out_bytes_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_last_segment   = out_last_ff;

`ifndef SYNTHESIS
   a_err_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_last_segment && (rsp_segment_bytes == '0))
      else $error("error transaction not a single final empty result");
   a_map_starts: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_command == CMD_MAP) |=> (state_ff == ST_MUL))
      else $error("map transaction not taken");
   a_emit_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (rem_ff != '0))
      else $error("segment walk running with nothing left");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      out_valid_in && out_last_in |=> !busy)
      else $error("busy after final result");
`endif
endmodule
`default_nettype wire
